// ===== rtl/core/point_distance_sorter_top_defines.svh =====
// Assertion macros for the point distance sorter.
// Each expects clk and rst_n to be visible where it is used.
`ifndef POINT_DISTANCE_SORTER_TOP_DEFINES_SVH
`define POINT_DISTANCE_SORTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PDS_ASSERT(lbl, prop, msg)
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/pds_pkg.sv =====
`default_nettype none

package pds_pkg;

  // Field widths of the point and result transfers.
  localparam int ID_W    = 8;
  localparam int COORD_W = 16;
  localparam int SQ_W    = 32;
  localparam int DIST_W  = 34;

  // Register indexes on the configuration port.
  localparam logic REG_START_X = 1'b0;
  localparam logic REG_START_Y = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } pds_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pds_dist_unit.sv =====
`default_nettype none

module pds_dist_unit
  import pds_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic signed [COORD_W-1:0] start_x,
  input  wire logic signed [COORD_W-1:0] start_y,
  output logic             [DIST_W-1:0]  dist_sq
);

  logic signed [COORD_W:0]     dx_r;
  logic signed [COORD_W:0]     dy_r;
  logic signed [2*COORD_W+1:0] prod_x;
  logic signed [2*COORD_W+1:0] prod_y;
  logic        [SQ_W-1:0]      sq_x_r;
  logic        [SQ_W-1:0]      sq_y_r;

  // First stage: differences to the start point, taken when a point is accepted.
  always_ff @(posedge clk) begin
    if (load) begin
      dx_r <= $signed({point_x[COORD_W-1], point_x}) - $signed({start_x[COORD_W-1], start_x});
      dy_r <= $signed({point_y[COORD_W-1], point_y}) - $signed({start_y[COORD_W-1], start_y});
    end
  end

  // Second stage: the squares. The difference magnitude is at most 65535, so its square stays below 2**32.
  assign prod_x = dx_r * dx_r;
  assign prod_y = dy_r * dy_r;

  always_ff @(posedge clk) begin
    sq_x_r <= prod_x[SQ_W-1:0];
    sq_y_r <= prod_y[SQ_W-1:0];
  end

  // The final sum is consumed by the store write.
  assign dist_sq = {{(DIST_W-SQ_W){1'b0}}, sq_x_r} + {{(DIST_W-SQ_W){1'b0}}, sq_y_r};

endmodule

`default_nettype wire

// ===== rtl/core/point_distance_sorter_top.sv =====
// Point distance sorter. Points are loaded with start while busy is low; a new
// point can be taken while the previous one is written. Each point's squared
// distance from the start point registers is stored with its identifier in a
// single memory. The point marked last_point is stored too, and the block then
// reports all stored points in ascending distance order, equal distances in load
// order, one result on the out_ ports per out_strobe pulse. The receiver cannot
// stall: every strobed result must be taken in that cycle. The run length is set
// by the memory's single read port, which is swept once over all entries for each
// result; busy falls in the cycle the final result is strobed. Points arriving
// while MAX_POINTS are held are dropped. The start point registers should only
// be written while busy is low.
`default_nettype none
`include "point_distance_sorter_top_defines.svh"

module point_distance_sorter_top
  import pds_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Point input
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic        [ID_W-1:0]    in_point_id,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic                      in_last_point,
  // Result output
  output logic                           out_strobe,
  output logic             [ID_W-1:0]    out_sorted_id,
  output logic             [DIST_W-1:0]  out_distance_sq,
  output logic                           out_last_result,
  // Configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic        [2:0]         paddr,
  input  wire logic        [31:0]        pwdata,
  output logic             [31:0]        prdata,
  output logic                           pready
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int WORD_W = ID_W + DIST_W;
  localparam int KEY_W  = DIST_W + AW;

  pds_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] start_x_r;
  logic signed [COORD_W-1:0] start_y_r;

  logic [CW-1:0]     count_r;
  logic [AW-1:0]     scan_r;
  logic [AW-1:0]     rank_r;
  logic              last_r;
  logic [ID_W-1:0]   id_r;
  logic              first_r;
  logic              rd_valid_r;
  logic [AW-1:0]     rd_idx_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              best_valid_r;
  logic [KEY_W-1:0]  best_key_r;
  logic [ID_W-1:0]   best_id_r;
  logic [KEY_W-1:0]  last_key_r;

  logic [WORD_W-1:0] mem [MAX_POINTS];

  logic              accept;
  logic              cfg_write;
  logic [DIST_W-1:0] dist_sq;
  logic              mem_we;
  logic              scan_last;
  logic              rank_last;
  logic [KEY_W-1:0]  cand_key;
  logic              cand_take;

  // Configuration registers; pready is tied high so each access ends at once.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_START_X: start_x_r <= pwdata[COORD_W-1:0];
        REG_START_Y: start_y_r <= pwdata[COORD_W-1:0];
        default:     start_x_r <= start_x_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_START_X: prdata = {{(32-COORD_W){start_x_r[COORD_W-1]}}, start_x_r};
      REG_START_Y: prdata = {{(32-COORD_W){start_y_r[COORD_W-1]}}, start_y_r};
      default:     prdata = '0;
    endcase
  end

  // Distance pipeline: difference on transfer, squares next cycle, sum at the write.
  assign accept = start && !busy;

  pds_dist_unit u_dist (
    .clk     (clk),
    .load    (accept),
    .point_x (in_point_x),
    .point_y (in_point_y),
    .start_x (start_x_r),
    .start_y (start_y_r),
    .dist_sq (dist_sq)
  );

  assign scan_last = (CW'(scan_r) == count_r - CW'(1));
  assign rank_last = (CW'(rank_r) == count_r - CW'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (last_r) state_nxt = ST_SCAN;
        else if (accept) state_nxt = ST_MUL;
        else state_nxt = ST_IDLE;
      end
      ST_SCAN:  if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = rank_last ? ST_IDLE : ST_SCAN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    busy   = 1'b1;
    mem_we = 1'b0;
    case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_WRITE: begin
        busy   = last_r;
        mem_we = (count_r < CW'(MAX_POINTS));
      end
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Point store: identifier and distance in one word, read one entry a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[AW-1:0]] <= {id_r, dist_sq};
    rd_data_r <= mem[scan_r];
  end

  // Fields of the accepted point that travel with the distance pipeline.
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r   <= in_point_id;
      last_r <= in_last_point;
    end
  end

  // Fill count, scan address and output rank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_r     <= '0;
      rank_r     <= '0;
      first_r    <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= (state_r == ST_SCAN);
      rd_idx_r   <= scan_r;
      case (state_r)
        ST_WRITE: begin
          if (mem_we) count_r <= count_r + CW'(1);
          scan_r  <= '0;
          rank_r  <= '0;
          first_r <= 1'b1;
        end
        ST_SCAN:  scan_r <= scan_r + AW'(1);
        ST_EMIT: begin
          scan_r  <= '0;
          rank_r  <= rank_r + AW'(1);
          first_r <= 1'b0;
          if (rank_last) count_r <= '0;
        end
        default:  scan_r <= scan_r;
      endcase
    end
  end

  // Search: the smallest (distance, load position) above the one last reported.
  assign cand_key  = {rd_data_r[DIST_W-1:0], rd_idx_r};
  assign cand_take = rd_valid_r && (first_r || (cand_key > last_key_r)) &&
                     (!best_valid_r || (cand_key < best_key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT || state_r == ST_WRITE) begin
      best_valid_r <= 1'b0;
    end else if (cand_take) begin
      best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_take) begin
      best_key_r <= cand_key;
      best_id_r  <= rd_data_r[WORD_W-1:DIST_W];
    end
    if (state_r == ST_EMIT) last_key_r <= best_key_r;
  end

  // Result register: one strobed transfer per completed search.
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= (state_r == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      out_sorted_id   <= best_id_r;
      out_distance_sq <= best_key_r[KEY_W-1:AW];
      out_last_result <= rank_last;
    end
  end

  // Checks on the controller.
  `PDS_ASSERT(a_strobe_after_emit, out_strobe |-> $past(state_r == ST_EMIT),
              "result without search")
  `PDS_ASSERT(a_run_end_empty,
              (out_strobe && out_last_result) |-> (state_r == ST_IDLE && count_r == '0),
              "store not emptied after run")
  `PDS_ASSERT(a_count_bound, count_r <= CW'(MAX_POINTS), "fill count beyond capacity")
  `PDS_ASSERT_NEXT(a_run_start, state_r == ST_WRITE && last_r,
                   state_r == ST_SCAN && rank_r == '0 && first_r,
                   "run did not start cleanly")

endmodule

`default_nettype wire
